// ===== hw/rtl/i2c_master_status_controller_core_defines.svh =====
// ----------------------------------------------------------------------------
// I2C master status controller: assertion macros
// Property wrappers for the port checker file of this block.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_STATUS_CONTROLLER_CORE_DEFINES_SVH
`define I2C_MASTER_STATUS_CONTROLLER_CORE_DEFINES_SVH

// Property checked on every rising edge, switched off while reset is held.
`define I2CM_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define I2CM_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== hw/rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master status controller: package
// Request codes, register selects, control bit positions, status codes and
// the bus phase and transfer kind types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cm_pkg;

  // Request types
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Register selects
  localparam logic [1:0] REG_CTL_SET = 2'd0;
  localparam logic [1:0] REG_STATUS  = 2'd1;
  localparam logic [1:0] REG_DATA    = 2'd2;
  localparam logic [1:0] REG_CTL_CLR = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SCL_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCL_LOW  = 1'b1;
  localparam logic [CFG_DATA_W-1:0] SCL_COUNT_RST = 16'd240;

  // Control bits as stored: byte bits 6..2 packed into 5 bits
  localparam int unsigned CTL_W   = 5;
  localparam int unsigned CTL_LSB = 2;
  localparam int unsigned CTL_AA  = 0;
  localparam int unsigned CTL_SI  = 1;
  localparam int unsigned CTL_STO = 2;
  localparam int unsigned CTL_STA = 3;
  localparam int unsigned CTL_EN  = 4;
  // STO is not clearable by software
  localparam logic [CTL_W-1:0] CTL_CLEARABLE = 5'b11011;

  // Status codes
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RSTART     = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK  = 8'h20;
  localparam logic [7:0] ST_TX_ACK     = 8'h28;
  localparam logic [7:0] ST_TX_NACK    = 8'h30;
  localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK  = 8'h48;
  localparam logic [7:0] ST_RX_ACK     = 8'h50;
  localparam logic [7:0] ST_RX_NACK    = 8'h58;
  localparam logic [7:0] ST_IDLE       = 8'hF8;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [8:0] {
    PH_IDLE        = 9'b000000001,
    PH_START_SETUP = 9'b000000010,
    PH_START_HOLD  = 9'b000000100,
    PH_WAIT        = 9'b000001000,
    PH_RS_LOW      = 9'b000010000,
    PH_STOP_LOW    = 9'b000100000,
    PH_STOP_HIGH   = 9'b001000000,
    PH_XFER_LOW    = 9'b010000000,
    PH_XFER_HIGH   = 9'b100000000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_ADDR = 2'd0,
    KIND_TX   = 2'd1,
    KIND_RX   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] reg_sel;
    logic [7:0] wdata;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       irq_flag;
  } rsp_t;

endpackage

// ===== hw/rtl/i2cm_req_if.sv =====
// ----------------------------------------------------------------------------
// I2C master status controller: request channel
// Valid/ready channel carrying one register access or one bus tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface i2cm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [1:0] reg_sel;
  logic [7:0] wdata;
  logic       sda_in;

  modport source (output valid, output req_type, output reg_sel, output wdata,
                  output sda_in, input ready);
  modport sink   (input valid, input req_type, input reg_sel, input wdata,
                  input sda_in, output ready);
endinterface

// ===== hw/rtl/i2cm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// I2C master status controller: result channel
// Valid/ready channel carrying read data, line drive and interrupt flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface i2cm_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic       scl_drive_low;
  logic       sda_drive_low;
  logic       irq_flag;

  modport source (output valid, output rdata, output scl_drive_low,
                  output sda_drive_low, output irq_flag, input ready);
  modport sink   (input valid, input rdata, input scl_drive_low,
                  input sda_drive_low, input irq_flag, output ready);
endinterface

// ===== hw/rtl/i2cm_engine.sv =====
// ----------------------------------------------------------------------------
// I2C master status controller: register file and bus engine
// Holds the control, status and data registers and the bus phase state;
// applies one request per step and reports read data and line drive.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cm_engine import i2cm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  req_t                  req,
  input  logic [CFG_DATA_W-1:0] scl_high,
  input  logic [CFG_DATA_W-1:0] scl_low,
  output rsp_t                  rsp
);

  logic [CTL_W-1:0]      ctrl_r,   ctrl_nxt;
  logic [7:0]            status_r, status_nxt;
  logic [7:0]            shift_r,  shift_nxt;
  logic [3:0]            bitcnt_r, bitcnt_nxt;
  phase_t                phase_r,  phase_nxt;
  kind_t                 kind_r,   kind_nxt;
  logic [CFG_DATA_W-1:0] pcnt_r,   pcnt_nxt;
  logic                  rmode_r,  rmode_nxt;
  logic                  active_r, active_nxt;

  logic [CFG_DATA_W-1:0] lim_high, lim_low, lim, pcnt_inc;
  logic                  use_low, pdone;
  logic [7:0]            rdata;
  logic [1:0]            drive;

  // A count of zero acts as one
  assign lim_high = (scl_high == '0) ? CFG_DATA_W'(1) : scl_high;
  assign lim_low  = (scl_low  == '0) ? CFG_DATA_W'(1) : scl_low;
  assign use_low  = (phase_r == PH_RS_LOW) || (phase_r == PH_STOP_LOW) ||
                    (phase_r == PH_XFER_LOW);
  assign lim      = use_low ? lim_low : lim_high;
  assign pcnt_inc = pcnt_r + CFG_DATA_W'(1);
  assign pdone    = (pcnt_inc >= lim);

  function automatic logic [1:0] line_drive(phase_t ph, kind_t k, logic [3:0] bc,
                                            logic [7:0] sh, logic aa);
    logic scl;
    logic sda;
    scl = 1'b0;
    sda = 1'b0;
    unique case (ph)
      PH_START_HOLD: sda = 1'b1;
      PH_WAIT: begin
        scl = 1'b1;
        sda = 1'b1;
      end
      PH_RS_LOW: scl = 1'b1;
      PH_STOP_LOW: begin
        scl = 1'b1;
        sda = 1'b1;
      end
      PH_STOP_HIGH: sda = 1'b1;
      PH_XFER_LOW, PH_XFER_HIGH: begin
        scl = (ph == PH_XFER_LOW);
        if (bc < BITS_PER_BYTE) begin
          sda = (k == KIND_RX) ? 1'b0 : ~sh[7];
        end else begin
          // acknowledge slot: drive ACK only when receiving with AA set
          sda = (k == KIND_RX) && aa;
        end
      end
      default: ;
    endcase
    return {scl, sda};
  endfunction

  always_comb begin
    ctrl_nxt   = ctrl_r;
    status_nxt = status_r;
    shift_nxt  = shift_r;
    bitcnt_nxt = bitcnt_r;
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    pcnt_nxt   = pcnt_r;
    rmode_nxt  = rmode_r;
    active_nxt = active_r;
    rdata      = 8'h00;

    if (step) begin
      unique case (req.req_type)
        REQ_TICK: begin
          if (!ctrl_r[CTL_EN]) begin
            phase_nxt  = PH_IDLE;
            pcnt_nxt   = '0;
            bitcnt_nxt = '0;
            active_nxt = 1'b0;
            status_nxt = ST_IDLE;
          end else begin
            unique case (phase_r)
              PH_IDLE: begin
                if (ctrl_r[CTL_STO]) begin
                  ctrl_nxt[CTL_STO] = 1'b0;
                end else if (ctrl_r[CTL_STA]) begin
                  phase_nxt  = PH_START_SETUP;
                  pcnt_nxt   = '0;
                  status_nxt = ST_IDLE;
                end
              end
              PH_START_SETUP: begin
                pcnt_nxt = pdone ? '0 : pcnt_inc;
                if (pdone) phase_nxt = PH_START_HOLD;
              end
              PH_START_HOLD: begin
                pcnt_nxt = pdone ? '0 : pcnt_inc;
                if (pdone) begin
                  status_nxt       = active_r ? ST_RSTART : ST_START;
                  ctrl_nxt[CTL_SI] = 1'b1;
                  phase_nxt        = PH_WAIT;
                  active_nxt       = 1'b1;
                end
              end
              PH_WAIT: begin
                if (!ctrl_r[CTL_SI]) begin
                  status_nxt = ST_IDLE;
                  pcnt_nxt   = '0;
                  if (ctrl_r[CTL_STO]) begin
                    phase_nxt = PH_STOP_LOW;
                  end else if (ctrl_r[CTL_STA]) begin
                    phase_nxt = PH_RS_LOW;
                  end else begin
                    // after a start the data byte goes out as the address
                    if (status_r == ST_START || status_r == ST_RSTART) begin
                      kind_nxt  = KIND_ADDR;
                      rmode_nxt = shift_r[0];
                    end else begin
                      kind_nxt = rmode_r ? KIND_RX : KIND_TX;
                    end
                    bitcnt_nxt = '0;
                    phase_nxt  = PH_XFER_LOW;
                  end
                end
              end
              PH_RS_LOW: begin
                pcnt_nxt = pdone ? '0 : pcnt_inc;
                if (pdone) phase_nxt = PH_START_SETUP;
              end
              PH_STOP_LOW: begin
                pcnt_nxt = pdone ? '0 : pcnt_inc;
                if (pdone) phase_nxt = PH_STOP_HIGH;
              end
              PH_STOP_HIGH: begin
                pcnt_nxt = pdone ? '0 : pcnt_inc;
                if (pdone) begin
                  phase_nxt         = PH_IDLE;
                  bitcnt_nxt        = '0;
                  active_nxt        = 1'b0;
                  status_nxt        = ST_IDLE;
                  ctrl_nxt[CTL_STO] = 1'b0;
                end
              end
              PH_XFER_LOW: begin
                pcnt_nxt = pdone ? '0 : pcnt_inc;
                if (pdone) phase_nxt = PH_XFER_HIGH;
              end
              PH_XFER_HIGH: begin
                pcnt_nxt = pdone ? '0 : pcnt_inc;
                if (pdone) begin
                  if (bitcnt_r < BITS_PER_BYTE) begin
                    // shift in the bus level on every data bit
                    shift_nxt  = {shift_r[6:0], req.sda_in};
                    bitcnt_nxt = bitcnt_r + 4'd1;
                    phase_nxt  = PH_XFER_LOW;
                  end else begin
                    bitcnt_nxt       = '0;
                    ctrl_nxt[CTL_SI] = 1'b1;
                    phase_nxt        = PH_WAIT;
                    case (kind_r)
                      KIND_RX:  status_nxt = ctrl_r[CTL_AA] ? ST_RX_ACK : ST_RX_NACK;
                      KIND_TX:  status_nxt = req.sda_in ? ST_TX_NACK : ST_TX_ACK;
                      default: begin
                        if (rmode_r) status_nxt = req.sda_in ? ST_SLAR_NACK : ST_SLAR_ACK;
                        else         status_nxt = req.sda_in ? ST_SLAW_NACK : ST_SLAW_ACK;
                      end
                    endcase
                  end
                end
              end
              default: begin
                phase_nxt  = PH_IDLE;
                pcnt_nxt   = '0;
                bitcnt_nxt = '0;
                active_nxt = 1'b0;
                status_nxt = ST_IDLE;
              end
            endcase
          end
        end
        REQ_WRITE: begin
          unique case (req.reg_sel)
            REG_CTL_SET: ctrl_nxt = ctrl_r | req.wdata[CTL_LSB +: CTL_W];
            REG_CTL_CLR: ctrl_nxt = ctrl_r & ~(req.wdata[CTL_LSB +: CTL_W] & CTL_CLEARABLE);
            REG_DATA:    shift_nxt = req.wdata;
            default: ;
          endcase
        end
        REQ_READ: begin
          unique case (req.reg_sel)
            REG_STATUS: rdata = status_r;
            REG_DATA:   rdata = shift_r;
            default:    rdata = {1'b0, ctrl_r, 2'b00};
          endcase
        end
        default: ;
      endcase
    end
  end

  assign drive = line_drive(phase_nxt, kind_nxt, bitcnt_nxt, shift_nxt, ctrl_nxt[CTL_AA]);

  always_comb begin
    rsp.rdata         = rdata;
    rsp.scl_drive_low = drive[1];
    rsp.sda_drive_low = drive[0];
    rsp.irq_flag      = ctrl_nxt[CTL_SI];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= '0;
      status_r <= ST_IDLE;
      shift_r  <= '0;
      bitcnt_r <= '0;
      phase_r  <= PH_IDLE;
      kind_r   <= KIND_ADDR;
      pcnt_r   <= '0;
      rmode_r  <= 1'b0;
      active_r <= 1'b0;
    end else begin
      ctrl_r   <= ctrl_nxt;
      status_r <= status_nxt;
      shift_r  <= shift_nxt;
      bitcnt_r <= bitcnt_nxt;
      phase_r  <= phase_nxt;
      kind_r   <= kind_nxt;
      pcnt_r   <= pcnt_nxt;
      rmode_r  <= rmode_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

// ===== hw/rtl/i2c_master_status_controller_core.sv =====
// ----------------------------------------------------------------------------
// I2C master status controller core
// Channel   | Dir | Payload                                      | Beat
// in_ch     | in  | req_type, reg_sel, wdata, sda_in             | valid & ready
// out_ch    | out | rdata, scl_drive_low, sda_drive_low, irq_flag | valid & ready
// cfg_*     | in  | cfg_idx, cfg_wdata (SCL high / low counts)   | cfg_we
//
// One request beat per cycle while in_ch.ready is high; its result beat is valid the cycle after.
// The engine computes each result combinationally; the result register is the only stage.
// in_ch.ready drops only while a result is held and out_ch.ready is low.
// rst_n is synchronous: engine state clears and both SCL counts return to 240.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_status_controller_core import i2cm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  i2cm_req_if.sink              in_ch,
  i2cm_rsp_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CFG_DATA_W-1:0] scl_high_r, scl_high_nxt;
  logic [CFG_DATA_W-1:0] scl_low_r,  scl_low_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rsp_t                  rsp_r;
  rsp_t                  rsp;
  req_t                  req;
  logic                  accept;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    req.req_type = in_ch.req_type;
    req.reg_sel  = in_ch.reg_sel;
    req.wdata    = in_ch.wdata;
    req.sda_in   = in_ch.sda_in;
  end

  always_comb begin
    scl_high_nxt = scl_high_r;
    scl_low_nxt  = scl_low_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SCL_HIGH: scl_high_nxt = cfg_wdata;
        CFG_SCL_LOW:  scl_low_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  i2cm_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (accept),
    .req      (req),
    .scl_high (scl_high_r),
    .scl_low  (scl_low_r),
    .rsp      (rsp)
  );

  // load on accept, drop once taken
  assign out_valid_nxt = accept ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scl_high_r  <= SCL_COUNT_RST;
      scl_low_r   <= SCL_COUNT_RST;
      out_valid_r <= 1'b0;
    end else begin
      scl_high_r  <= scl_high_nxt;
      scl_low_r   <= scl_low_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) rsp_r <= rsp;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.rdata         = rsp_r.rdata;
  assign out_ch.scl_drive_low = rsp_r.scl_drive_low;
  assign out_ch.sda_drive_low = rsp_r.sda_drive_low;
  assign out_ch.irq_flag      = rsp_r.irq_flag;

endmodule

// ===== hw/rtl/i2cm_checker.sv =====
// ----------------------------------------------------------------------------
// I2C master status controller: port checker
// Watches the request and result channels of the core over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_master_status_controller_core_defines.svh"

module i2cm_checker import i2cm_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_req_type,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_rdata
);

  `I2CM_ASSERT_ALWAYS(a_rst_clears_out, clk, !rst_n |=> !out_valid, "result valid after reset")
  `I2CM_ASSERT(a_accept_gives_result, clk, rst_n, (in_valid && in_ready) |=> out_valid, "accepted beat gave no result")
  `I2CM_ASSERT(a_ready_when_free, clk, rst_n, (!out_valid || out_ready) |-> in_ready, "input stalled with free result slot")
  `I2CM_ASSERT(a_tick_reads_zero, clk, rst_n, (in_valid && in_ready && in_req_type == REQ_TICK) |=> (out_rdata == 8'h00), "tick returned nonzero read data")
  `I2CM_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "result dropped while stalled")

endmodule

bind i2c_master_status_controller_core i2cm_checker u_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_req_type (in_ch.req_type),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_rdata   (out_ch.rdata)
);

// ===== tb/i2cm_status_checker.sv =====
// ----------------------------------------------------------------------------
// I2C master status controller: response checker
// Watches the request, response and timing ports, keeps its own copy of the
// bus engine, and compares every response beat against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cm_status_checker import i2cm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  i2cm_req_if                   req_mon,
  i2cm_rsp_if                   rsp_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           mismatches,
  output int unsigned           outstanding
);

  logic [CFG_DATA_W-1:0] scl_high_len;
  logic [CFG_DATA_W-1:0] scl_low_len;
  logic [CTL_W-1:0]      ctl_q;
  logic [7:0]            status_q;
  logic [7:0]            shift_q;
  logic [3:0]            bit_cnt;
  phase_t                phase_q;
  kind_t                 kind_q;
  logic [15:0]           period_cnt;
  logic                  read_mode;
  logic                  bus_owned;

  rsp_t expected_rsp[$];

  function automatic void reset_engine();
    scl_high_len = SCL_COUNT_RST;
    scl_low_len  = SCL_COUNT_RST;
    ctl_q        = '0;
    status_q     = ST_IDLE;
    shift_q      = '0;
    bit_cnt      = '0;
    phase_q      = PH_IDLE;
    kind_q       = KIND_ADDR;
    period_cnt   = '0;
    read_mode    = 1'b0;
    bus_owned    = 1'b0;
  endfunction

  // A zero count behaves as one tick.
  function automatic logic period_elapsed(input logic [15:0] len);
    logic [15:0] lim;
    lim = (len == '0) ? 16'd1 : len;
    period_cnt = period_cnt + 16'd1;
    if (period_cnt >= lim) begin
      period_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void post_status(input logic [7:0] code);
    status_q       = code;
    ctl_q[CTL_SI]  = 1'b1;
    phase_q        = PH_WAIT;
    period_cnt     = '0;
  endfunction

  function automatic void drop_to_idle();
    phase_q    = PH_IDLE;
    period_cnt = '0;
    bit_cnt    = '0;
    bus_owned  = 1'b0;
    status_q   = ST_IDLE;
  endfunction

  function automatic void end_high_period(input logic sda);
    if (bit_cnt < BITS_PER_BYTE) begin
      shift_q = {shift_q[6:0], sda};
      bit_cnt = bit_cnt + 4'd1;
      phase_q = PH_XFER_LOW;
      return;
    end
    // ninth bit: the acknowledge
    bit_cnt = '0;
    case (kind_q)
      KIND_RX: post_status(ctl_q[CTL_AA] ? ST_RX_ACK : ST_RX_NACK);
      KIND_TX: post_status(sda ? ST_TX_NACK : ST_TX_ACK);
      default: begin
        if (read_mode) post_status(sda ? ST_SLAR_NACK : ST_SLAR_ACK);
        else post_status(sda ? ST_SLAW_NACK : ST_SLAW_ACK);
      end
    endcase
  endfunction

  function automatic void resume_after_wait();
    logic [7:0] prev;
    prev       = status_q;
    status_q   = ST_IDLE;
    period_cnt = '0;
    if (ctl_q[CTL_STO]) begin
      phase_q = PH_STOP_LOW;
      return;
    end
    if (ctl_q[CTL_STA]) begin
      phase_q = PH_RS_LOW;
      return;
    end
    if (prev == ST_START || prev == ST_RSTART) begin
      kind_q    = KIND_ADDR;
      read_mode = shift_q[0];
    end else begin
      kind_q = read_mode ? KIND_RX : KIND_TX;
    end
    bit_cnt = '0;
    phase_q = PH_XFER_LOW;
  endfunction

  function automatic void bus_tick(input logic sda);
    if (!ctl_q[CTL_EN]) begin
      drop_to_idle();
      return;
    end
    case (phase_q)
      PH_IDLE: begin
        if (ctl_q[CTL_STO]) begin
          ctl_q[CTL_STO] = 1'b0;
        end else if (ctl_q[CTL_STA]) begin
          phase_q    = PH_START_SETUP;
          period_cnt = '0;
          status_q   = ST_IDLE;
        end
      end
      PH_START_SETUP: if (period_elapsed(scl_high_len)) phase_q = PH_START_HOLD;
      PH_START_HOLD: begin
        if (period_elapsed(scl_high_len)) begin
          post_status(bus_owned ? ST_RSTART : ST_START);
          bus_owned = 1'b1;
        end
      end
      PH_WAIT: if (!ctl_q[CTL_SI]) resume_after_wait();
      PH_RS_LOW: if (period_elapsed(scl_low_len)) phase_q = PH_START_SETUP;
      PH_STOP_LOW: if (period_elapsed(scl_low_len)) phase_q = PH_STOP_HIGH;
      PH_STOP_HIGH: begin
        if (period_elapsed(scl_high_len)) begin
          drop_to_idle();
          ctl_q[CTL_STO] = 1'b0;
        end
      end
      PH_XFER_LOW: if (period_elapsed(scl_low_len)) phase_q = PH_XFER_HIGH;
      PH_XFER_HIGH: if (period_elapsed(scl_high_len)) end_high_period(sda);
      default: drop_to_idle();
    endcase
  endfunction

  function automatic rsp_t engine_step(input logic [1:0] rt, input logic [1:0] sel,
                                       input logic [7:0] wd, input logic sda);
    rsp_t r;
    r = '0;
    case (rt)
      REQ_TICK: bus_tick(sda);
      REQ_WRITE: begin
        case (sel)
          REG_CTL_SET: ctl_q = ctl_q | wd[CTL_LSB +: CTL_W];
          REG_CTL_CLR: ctl_q = ctl_q & ~(wd[CTL_LSB +: CTL_W] & CTL_CLEARABLE);
          REG_DATA:    shift_q = wd;
          default:     ;
        endcase
      end
      REQ_READ: begin
        case (sel)
          REG_STATUS: r.rdata = status_q;
          REG_DATA:   r.rdata = shift_q;
          default:    r.rdata = {1'b0, ctl_q, 2'b00};
        endcase
      end
      default: ;
    endcase

    case (phase_q)
      PH_START_HOLD: r.sda_drive_low = 1'b1;
      PH_WAIT: begin
        r.scl_drive_low = 1'b1;
        r.sda_drive_low = 1'b1;
      end
      PH_RS_LOW: r.scl_drive_low = 1'b1;
      PH_STOP_LOW: begin
        r.scl_drive_low = 1'b1;
        r.sda_drive_low = 1'b1;
      end
      PH_STOP_HIGH: r.sda_drive_low = 1'b1;
      PH_XFER_LOW, PH_XFER_HIGH: begin
        r.scl_drive_low = (phase_q == PH_XFER_LOW);
        if (bit_cnt < BITS_PER_BYTE) r.sda_drive_low = (kind_q == KIND_RX) ? 1'b0 : ~shift_q[7];
        else r.sda_drive_low = (kind_q == KIND_RX) && ctl_q[CTL_AA];
      end
      default: ;
    endcase
    r.irq_flag = ctl_q[CTL_SI];
    return r;
  endfunction

  function automatic void check_field(input string fname, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%02h, actual 0x%02h", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    rsp_t want;
    if (!rst_n) begin
      reset_engine();
      expected_rsp.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_SCL_HIGH) scl_high_len = cfg_wdata;
        else if (cfg_idx == CFG_SCL_LOW) scl_low_len = cfg_wdata;
      end
      if (req_mon.valid && req_mon.ready)
        expected_rsp.push_back(engine_step(req_mon.req_type, req_mon.reg_sel,
                                           req_mon.wdata, req_mon.sda_in));
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: response beat with nothing expected: actual rdata 0x%02h",
                   $time, rsp_mon.rdata);
          mismatches++;
        end else begin
          want = expected_rsp.pop_front();
          check_field("rdata", want.rdata, rsp_mon.rdata);
          check_field("scl_drive_low", {7'd0, want.scl_drive_low}, {7'd0, rsp_mon.scl_drive_low});
          check_field("sda_drive_low", {7'd0, want.sda_drive_low}, {7'd0, rsp_mon.sda_drive_low});
          check_field("irq_flag", {7'd0, want.irq_flag}, {7'd0, rsp_mon.irq_flag});
        end
      end
    end
    outstanding = expected_rsp.size();
  end

endmodule

// ===== tb/i2c_master_status_controller_core_tb.sv =====
// ----------------------------------------------------------------------------
// I2C master status controller: testbench top
// Drives register accesses and bus ticks as software would run transfers,
// mixed with noise, under several SCL timings and idle/stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_status_controller_core_tb import i2cm_pkg::*;;

  localparam logic [1:0] REQ_NONE    = 2'd3;
  localparam logic [7:0] CB_AA       = 8'd1 << (CTL_LSB + CTL_AA);
  localparam logic [7:0] CB_SI       = 8'd1 << (CTL_LSB + CTL_SI);
  localparam logic [7:0] CB_STO      = 8'd1 << (CTL_LSB + CTL_STO);
  localparam logic [7:0] CB_STA      = 8'd1 << (CTL_LSB + CTL_STA);
  localparam logic [7:0] CB_EN       = 8'd1 << (CTL_LSB + CTL_EN);
  localparam logic [7:0] CB_ALL      = {1'b0, {CTL_W{1'b1}}, 2'b00};
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned beats_sent = 0;
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned scl_hi     = 240;
  int unsigned scl_lo     = 240;
  int unsigned quiet_cycles = 0;
  bit          hold_req   = 1'b0;

  i2cm_req_if in_ch();
  i2cm_rsp_if out_ch();

  i2c_master_status_controller_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  i2cm_status_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (in_ch),
    .rsp_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Response side: random stalls, plus one long hold-off so the input backs up.
  initial begin : response_sink
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [1:0] rt, input logic [1:0] sel,
                           input logic [7:0] wd, input logic sda);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= rt;
    in_ch.reg_sel  <= sel;
    in_ch.wdata    <= wd;
    in_ch.sda_in   <= sda;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic reg_write(input logic [1:0] sel, input logic [7:0] wd);
    send_beat(REQ_WRITE, sel, wd, 1'($urandom_range(1)));
  endtask

  task automatic reg_read(input logic [1:0] sel);
    send_beat(REQ_READ, sel, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic run_ticks(input int unsigned n);
    repeat (n) send_beat(REQ_TICK, 2'($urandom_range(3)), 8'($urandom_range(255)),
                         1'($urandom_range(1)));
  endtask

  // Usually wait the full phase plus slack; now and then cut it short.
  task automatic wait_ticks(input int unsigned n);
    int unsigned k;
    k = n + $urandom_range(3);
    if ($urandom_range(9) == 0) k = n / 2;
    run_ticks(k);
  endtask

  // Byte on the bus, sometimes poked by software partway through.
  task automatic byte_ticks(input int unsigned n);
    int unsigned total;
    int unsigned k;
    total = n + $urandom_range(3);
    if ($urandom_range(3) == 0) begin
      k = $urandom_range(1, total - 1);
      run_ticks(k);
      case ($urandom_range(3))
        0:       reg_write(REG_DATA, 8'($urandom_range(255)));
        1:       reg_write(REG_CTL_SET, CB_SI);
        2:       reg_read(REG_DATA);
        default: reg_read(REG_STATUS);
      endcase
      run_ticks(total - k);
    end else begin
      run_ticks(total);
    end
  endtask

  task automatic send_address(input int unsigned t_byte);
    reg_write(REG_DATA, 8'($urandom_range(255)));
    reg_write(REG_CTL_CLR, CB_SI | CB_STA);
    byte_ticks(t_byte);
    reg_read(REG_STATUS);
  endtask

  task automatic run_transfer();
    int unsigned t_start;
    int unsigned t_byte;
    int unsigned t_stop;
    t_start = 2 + 2 * scl_hi;
    t_byte  = 1 + 9 * (scl_hi + scl_lo);
    t_stop  = 1 + scl_hi + scl_lo;
    reg_write(REG_CTL_SET, CB_EN | CB_STA | ($urandom_range(1) ? CB_AA : 8'h00));
    wait_ticks(t_start);
    reg_read(REG_STATUS);
    send_address(t_byte);
    repeat ($urandom_range(3)) begin
      if ($urandom_range(7) == 0) begin
        reg_write(REG_CTL_SET, CB_STA);
        reg_write(REG_CTL_CLR, CB_SI);
        wait_ticks(1 + scl_lo + 2 * scl_hi);
        send_address(t_byte);
      end else begin
        if ($urandom_range(3) != 0) reg_write(REG_DATA, 8'($urandom_range(255)));
        if ($urandom_range(2) == 0)
          reg_write($urandom_range(1) ? REG_CTL_SET : REG_CTL_CLR, CB_AA);
        reg_write(REG_CTL_CLR, CB_SI);
        byte_ticks(t_byte);
        if ($urandom_range(1)) reg_read(REG_DATA);
        reg_read(REG_STATUS);
      end
    end
    case ($urandom_range(3))
      0, 1: begin
        reg_write(REG_CTL_SET, CB_STO);
        reg_write(REG_CTL_CLR, CB_SI);
        wait_ticks(t_stop + 1);
      end
      2: begin
        // STOP wins over START, then the idle engine starts afresh
        reg_write(REG_CTL_SET, CB_STO | CB_STA);
        reg_write(REG_CTL_CLR, CB_SI);
        wait_ticks(t_stop + t_start);
        reg_read(REG_STATUS);
        reg_write(REG_CTL_SET, CB_STO);
        reg_write(REG_CTL_CLR, CB_SI | CB_STA);
        wait_ticks(t_stop + 1);
      end
      default: begin
        reg_write(REG_CTL_CLR, CB_EN);
        run_ticks(1);
      end
    endcase
  endtask

  // Drop every clearable bit and tick once with the interface off: engine idle.
  task automatic go_quiet();
    reg_write(REG_CTL_CLR, CB_ALL);
    run_ticks(1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timing(input int unsigned hi, input int unsigned lo);
    go_quiet();
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_SCL_HIGH;
    cfg_wdata <= CFG_DATA_W'(hi);
    @(posedge clk);
    cfg_idx   <= CFG_SCL_LOW;
    cfg_wdata <= CFG_DATA_W'(lo);
    @(posedge clk);
    cfg_we    <= 1'b0;
    scl_hi = hi;
    scl_lo = lo;
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned hi, input int unsigned lo,
                           input int unsigned goal, input bit squeeze);
    int unsigned mark;
    set_timing(hi, lo);
    idle_pct  = idle;
    stall_pct = stall;
    hold_req  = squeeze;
    mark = beats_sent + goal;
    while (beats_sent < mark) begin
      if ($urandom_range(5) == 0) begin
        repeat ($urandom_range(1, 8))
          send_beat(2'($urandom_range(3)), 2'($urandom_range(3)),
                    8'($urandom_range(255)), 1'($urandom_range(1)));
        go_quiet();
      end else begin
        run_transfer();
      end
    end
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_TICK;
    in_ch.reg_sel  = REG_CTL_SET;
    in_ch.wdata    = 8'h00;
    in_ch.sda_in   = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_SCL_HIGH;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register-level corner cases at reset timing
    reg_read(REG_CTL_SET);
    reg_read(REG_STATUS);
    reg_read(REG_DATA);
    reg_read(REG_CTL_CLR);
    send_beat(REQ_NONE, REG_DATA, 8'hFF, 1'b1);
    reg_write(REG_STATUS, 8'hFF);
    reg_read(REG_STATUS);
    reg_write(REG_DATA, 8'hFF);
    reg_read(REG_DATA);
    reg_write(REG_DATA, 8'h00);
    reg_read(REG_DATA);
    run_ticks(2);
    reg_write(REG_CTL_SET, 8'hFF);
    reg_read(REG_CTL_SET);
    reg_write(REG_CTL_CLR, 8'hFF);
    reg_read(REG_CTL_CLR);
    reg_write(REG_CTL_SET, CB_EN);
    run_ticks(1);
    reg_read(REG_CTL_SET);

    // widest SCL counts: a START held in setup, still no status posted
    set_timing(CFG_DATA_W'('1), CFG_DATA_W'('1));
    reg_write(REG_CTL_SET, CB_EN | CB_STA);
    run_ticks(16);
    reg_read(REG_STATUS);

    run_phase(0, 0, 4, 4, 240, 1'b1);
    run_phase(60, 0, $urandom_range(4, 8), $urandom_range(4, 8), 240, 1'b0);
    run_phase(0, 60, $urandom_range(4, 8), $urandom_range(4, 8), 240, 1'b0);
    run_phase(17, 17, $urandom_range(4, 8), $urandom_range(4, 8), 240, 1'b0);
    go_quiet();
    drain();

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_req_if.sv
hw/rtl/i2cm_rsp_if.sv
hw/rtl/i2cm_engine.sv
hw/rtl/i2c_master_status_controller_core.sv
hw/rtl/i2cm_checker.sv
tb/i2cm_status_checker.sv
tb/i2c_master_status_controller_core_tb.sv
